>>> src/pdts_pkg.sv
// ----------------------------------------------------------------------------
// pdts_pkg
// shared constants and types for the priority deadline task scheduler
// ----------------------------------------------------------------------------
package pdts_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int NumLevelsDefault  = 4;

  localparam logic OP_SUBMIT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [2:0] KIND_ACCEPTED   = 3'd0;
  localparam logic [2:0] KIND_REJECTED   = 3'd1;
  localparam logic [2:0] KIND_EXPIRED    = 3'd2;
  localparam logic [2:0] KIND_DISPATCHED = 3'd3;
  localparam logic [2:0] KIND_NONE       = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  priority_req;
    logic [63:0] deadline;
    logic [63:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] task_id;
    logic [1:0]  task_priority;
    logic [63:0] task_deadline;
    logic        last;
    logic [6:0]  pending_count;
  } res_t;

endpackage

>>> src/pdts_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pdts_cmd_fifo
// two-entry command queue between the intake side and the execution engine
// ----------------------------------------------------------------------------
module pdts_cmd_fifo
  import pdts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr_en && !full) wp <= ~wp;
      if (rd_en && !empty) rp <= ~rp;
      cnt <= cnt + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
    end
  end

endmodule

>>> src/pdts_engine.sv
// ----------------------------------------------------------------------------
// pdts_engine executes submit and dispatch commands on the level queues,
// one result a cycle while results are taken and no lower-level read is pending
// ----------------------------------------------------------------------------
module pdts_engine
  import pdts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int NUM_LEVELS  = NumLevelsDefault
)(
  input  logic clk,
  input  logic rst,
  input  logic expire_en,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_valid,
  output res_t res,
  input  logic res_take
);

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int SW  = QW + 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LW  = (NUM_LEVELS > 4) ? 3 : 2;
  localparam int NF  = NUM_LEVELS - 1;
  localparam int FA  = $clog2(NF * QUEUE_DEPTH);
  localparam int TW  = (NUM_LEVELS * QUEUE_DEPTH > 126) ?
                       $clog2(NUM_LEVELS * QUEUE_DEPTH + 2) : 8;
  localparam logic [LW-1:0] RtLevel = LW'(NUM_LEVELS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIFO = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // realtime queue: sorted register file, head at index 0
  logic [31:0] rt_ids [QUEUE_DEPTH];
  logic [63:0] rt_dls [QUEUE_DEPTH];
  // lower-level rings in one memory
  logic [31:0] fifo_ids [NF*QUEUE_DEPTH];
  logic [63:0] fifo_dls [NF*QUEUE_DEPTH];
  logic [31:0] rd_id;
  logic [63:0] rd_dl;
  logic [1:0]  rd_lvl;
  logic [FA-1:0] rd_ptr;

  logic [FW-1:0] fill [NUM_LEVELS];
  logic [QW-1:0] head [NF];
  logic [31:0]   next_id;
  logic [1:0]    state;
  logic [TW-1:0] total;

  // output register
  logic out_full;
  res_t out_r;
  assign res_valid = out_full;
  assign res = out_r;
  logic can_emit;
  assign can_emit = !out_full || res_take;

  logic [LW-1:0] lvl;
  always_comb begin
    lvl = LW'(cmd.priority_req);
    if (32'(cmd.priority_req) >= NUM_LEVELS) lvl = RtLevel;
  end

  always_comb begin
    total = '0;
    for (int l = 0; l < NUM_LEVELS; l++) total = total + TW'(fill[l]);
  end
  logic [6:0] sat_total_m1, sat_total_p1;
  logic [TW-1:0] tm1, tp1;
  assign tm1 = total - TW'(1);
  assign tp1 = total + TW'(1);
  assign sat_total_m1 = (tm1 > TW'(127)) ? 7'd127 : tm1[6:0];
  assign sat_total_p1 = (tp1 > TW'(127)) ? 7'd127 : tp1[6:0];
  logic [6:0] sat_total;
  assign sat_total = (total > TW'(127)) ? 7'd127 : total[6:0];

  // highest non-empty lower level
  logic          any_fifo;
  logic [LW-1:0] top_fifo;
  always_comb begin
    any_fifo = 1'b0; top_fifo = '0;
    for (int l = 0; l < NF; l++)
      if (fill[l] != '0) begin any_fifo = 1'b1; top_fifo = LW'(l); end
  end

  // insertion position: count of entries with deadline <= new
  logic [QUEUE_DEPTH-1:0] le;
  always_comb
    for (int i = 0; i < QUEUE_DEPTH; i++)
      le[i] = (FW'(i) < fill[NF]) && (rt_dls[i] <= cmd.deadline);

  logic rt_ne, rt_exp;
  assign rt_ne  = fill[NF] != '0;
  assign rt_exp = expire_en && rt_ne && (rt_dls[0] < cmd.now_time);

  logic lvl_full;
  assign lvl_full = fill[lvl] == FW'(QUEUE_DEPTH);

  // ring write slot: head plus fill, wrapped by one compare and subtract
  logic [QW-1:0] wr_head;
  logic [SW-1:0] slot_sum;
  logic [QW-1:0] slot;
  always_comb begin
    wr_head  = head[(lvl < LW'(NF)) ? lvl : '0];
    slot_sum = SW'(wr_head) + SW'(fill[lvl]);
    slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                               : QW'(slot_sum);
  end

  logic [FA-1:0] wr_addr, rd_addr;
  assign wr_addr = FA'(32'(lvl) * QUEUE_DEPTH + 32'(slot));
  assign rd_addr = FA'(32'(top_fifo) * QUEUE_DEPTH + 32'(head[top_fifo]));

  logic idle_act;
  assign idle_act = (state == ST_IDLE) && cmd_valid && can_emit;
  assign cmd_take = (idle_act && (cmd.opcode == OP_SUBMIT ||
                     (!rt_exp && (rt_ne || !any_fifo)))) ||
                    ((state == ST_EMIT) && can_emit);

  // dispatch from a lower level goes through the memory read stage
  logic fifo_path;
  assign fifo_path = (cmd.opcode == OP_DISPATCH) && !rt_exp && !rt_ne && any_fifo;
  logic emit_now;
  assign emit_now = (idle_act && !fifo_path) || ((state == ST_EMIT) && can_emit);

  always_ff @(posedge clk) begin
    if (idle_act && cmd.opcode == OP_SUBMIT && !lvl_full && lvl != RtLevel) begin
      fifo_ids[wr_addr] <= next_id;
      fifo_dls[wr_addr] <= cmd.deadline;
    end
    if (state == ST_FIFO) begin
      rd_id <= fifo_ids[rd_ptr];
      rd_dl <= fifo_dls[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (idle_act && cmd.opcode == OP_SUBMIT && !lvl_full && lvl == RtLevel) begin
      if (!le[0]) begin
        rt_ids[0] <= next_id; rt_dls[0] <= cmd.deadline;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            rt_ids[i] <= next_id; rt_dls[i] <= cmd.deadline;
          end else begin
            rt_ids[i] <= rt_ids[i-1]; rt_dls[i] <= rt_dls[i-1];
          end
        end
      end
    end else if (idle_act && cmd.opcode == OP_DISPATCH && (rt_exp || rt_ne)) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        rt_ids[i] <= rt_ids[i+1]; rt_dls[i] <= rt_dls[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_full <= 1'b0; next_id <= 32'd1;
      for (int l = 0; l < NUM_LEVELS; l++) fill[l] <= '0;
      for (int l = 0; l < NF; l++) head[l] <= '0;
    end else begin
      out_full <= emit_now || (out_full && !res_take);
      case (state)
        ST_IDLE: if (idle_act) begin
          if (cmd.opcode == OP_SUBMIT) begin
            out_r.last <= 1'b1;
            out_r.task_priority <= 2'(lvl);
            out_r.task_deadline <= cmd.deadline;
            if (lvl_full) begin
              out_r.kind <= KIND_REJECTED; out_r.task_id <= '0;
              out_r.pending_count <= sat_total;
            end else begin
              out_r.kind <= KIND_ACCEPTED; out_r.task_id <= next_id;
              out_r.pending_count <= sat_total_p1;
              next_id <= (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
              fill[lvl] <= fill[lvl] + FW'(1);
            end
          end else if (rt_exp || rt_ne) begin
            out_r.kind <= rt_exp ? KIND_EXPIRED : KIND_DISPATCHED;
            out_r.task_id <= rt_ids[0];
            out_r.task_priority <= 2'(RtLevel);
            out_r.task_deadline <= rt_dls[0];
            out_r.last <= !rt_exp;
            out_r.pending_count <= sat_total_m1;
            fill[NF] <= fill[NF] - FW'(1);
          end else if (any_fifo) begin
            rd_lvl <= 2'(top_fifo);
            rd_ptr <= rd_addr;
            head[top_fifo] <= (head[top_fifo] == QW'(QUEUE_DEPTH - 1)) ? '0 :
                              head[top_fifo] + QW'(1);
            fill[top_fifo] <= fill[top_fifo] - FW'(1);
            state <= ST_FIFO;
          end else begin
            out_r.kind <= KIND_NONE; out_r.task_id <= '0;
            out_r.task_priority <= '0; out_r.task_deadline <= '0;
            out_r.last <= 1'b1; out_r.pending_count <= sat_total;
          end
        end
        ST_FIFO: state <= ST_EMIT;
        ST_EMIT: if (can_emit) begin
          out_r.kind <= KIND_DISPATCHED; out_r.task_id <= rd_id;
          out_r.task_priority <= rd_lvl; out_r.task_deadline <= rd_dl;
          out_r.last <= 1'b1; out_r.pending_count <= sat_total;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[NF] <= FW'(QUEUE_DEPTH)) else $error("rt fill overflow");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != 32'd0) else $error("zero id");
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> !cmd_take || can_emit) else $error("take w/o emit");

endmodule

>>> src/priority_deadline_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_deadline_task_scheduler_top
// four-level task queue with deadline-ordered realtime level
// ----------------------------------------------------------------------------
// channel   | direction | transfer when
// commands  | in        | push && !full
// results   | out       | pop && !empty
// config    | in        | expire_en_we
//
// a submit passes through the command queue, then the engine insert (parallel shift)
// a dispatch from a lower level also goes through the memory read and emit states
// each expired realtime task adds its own result, one result per cycle while results are taken
// reset: synchronous, clears fills, heads, id counter, mode
// either side can stall; a two-entry command queue decouples them
module priority_deadline_task_scheduler_top
  import pdts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int NUM_LEVELS  = NumLevelsDefault
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        expire_en_we,
  input  logic        expire_en_wdata,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [1:0]  priority_req,
  input  logic [63:0] deadline,
  input  logic [63:0] now_time,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [31:0] task_id,
  output logic [1:0]  task_priority,
  output logic [63:0] task_deadline,
  output logic        last,
  output logic [6:0]  pending_count
);

  logic expire_en;
  always_ff @(posedge clk) begin
    if (rst) expire_en <= 1'b0;
    else if (expire_en_we) expire_en <= expire_en_wdata;
  end

  cmd_t in_cmd, q_cmd;
  logic q_empty, q_take, rv;
  res_t r;
  assign in_cmd = '{opcode, priority_req, deadline, now_time};

  pdts_cmd_fifo u_q (
    .clk, .rst, .wr_en(push), .wr_data(in_cmd), .full,
    .rd_en(q_take), .rd_data(q_cmd), .empty(q_empty)
  );

  pdts_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_LEVELS(NUM_LEVELS)) u_eng (
    .clk, .rst, .expire_en, .cmd_valid(!q_empty), .cmd(q_cmd),
    .cmd_take(q_take), .res_valid(rv), .res(r), .res_take(pop)
  );

  assign empty = !rv;
  assign kind = r.kind;
  assign task_id = r.task_id;
  assign task_priority = r.task_priority;
  assign task_deadline = r.task_deadline;
  assign last = r.last;
  assign pending_count = r.pending_count;

endmodule

>>> tb/tb_priority_deadline_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// tb_priority_deadline_task_scheduler_top
// self-checking bench: directed table, a realtime expiry run, then random submits and dispatches,
// every result compared against an in-bench scheduler model
// ----------------------------------------------------------------------------
module tb_priority_deadline_task_scheduler_top
  import pdts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = QueueDepthDefault;
  localparam int LEVELS  = NumLevelsDefault;
  localparam int RT_LVL  = LEVELS - 1;
  localparam int MAX_CYC = 2000000;
  localparam logic [63:0] DL_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic expire_en_we = 1'b0;
  logic expire_en_wdata = 1'b0;
  logic push = 1'b0;
  logic full;
  logic opcode = OP_SUBMIT;
  logic [1:0] priority_req = '0;
  logic [63:0] deadline = '0;
  logic [63:0] now_time = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] kind;
  logic [31:0] task_id;
  logic [1:0] task_priority;
  logic [63:0] task_deadline;
  logic last;
  logic [6:0] pending_count;

  priority_deadline_task_scheduler_top dut (
    .clk(clk), .rst(rst),
    .expire_en_we(expire_en_we), .expire_en_wdata(expire_en_wdata),
    .push(push), .full(full), .opcode(opcode), .priority_req(priority_req),
    .deadline(deadline), .now_time(now_time),
    .empty(empty), .pop(pop), .kind(kind), .task_id(task_id),
    .task_priority(task_priority), .task_deadline(task_deadline),
    .last(last), .pending_count(pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler model state
  logic [31:0] rt_id_q[$];
  logic [63:0] rt_dl_q[$];
  logic [31:0] lvl_id_q[RT_LVL][$];
  logic [63:0] lvl_dl_q[RT_LVL][$];
  logic [31:0] id_counter;
  logic        mode_rt;

  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  bit   hold_pop = 1'b0;
  bit   hold_go = 1'b0;

  function automatic logic [6:0] tasks_waiting();
    int s;
    s = rt_id_q.size();
    for (int l = 0; l < RT_LVL; l++) s += lvl_id_q[l].size();
    return (s > 127) ? 7'd127 : 7'(s);
  endfunction

  function automatic void add_result(logic [2:0] k, logic [31:0] id, logic [1:0] lv,
                                     logic [63:0] dl);
    res_t r;
    r.kind = k; r.task_id = id; r.task_priority = lv; r.task_deadline = dl;
    r.last = 1'b0; r.pending_count = tasks_waiting();
    expected_results.push_back(r);
  endfunction

  // apply one command to the model and queue the results it causes
  function automatic void schedule_cmd(cmd_t c);
    int lv, pos;
    bit found;
    logic [31:0] id;
    res_t r;
    lv = c.priority_req;
    if (c.opcode == OP_SUBMIT) begin
      if ((lv == RT_LVL ? rt_id_q.size() : lvl_id_q[lv].size()) >= DEPTH) begin
        add_result(KIND_REJECTED, '0, 2'(lv), c.deadline);
      end else begin
        id = id_counter;
        id_counter++;
        if (id_counter == 0) id_counter = 1;
        if (lv == RT_LVL) begin
          // stable insert: after every equal deadline
          pos = 0;
          while (pos < rt_dl_q.size() && rt_dl_q[pos] <= c.deadline) pos++;
          rt_id_q.insert(pos, id);
          rt_dl_q.insert(pos, c.deadline);
        end else begin
          lvl_id_q[lv].push_back(id);
          lvl_dl_q[lv].push_back(c.deadline);
        end
        add_result(KIND_ACCEPTED, id, 2'(lv), c.deadline);
      end
    end else begin
      found = 1'b0;
      if (mode_rt) begin
        while (rt_id_q.size() > 0 && rt_dl_q[0] < c.now_time) begin
          id = rt_id_q.pop_front();
          add_result(KIND_EXPIRED, id, 2'(RT_LVL), rt_dl_q.pop_front());
        end
      end
      if (rt_id_q.size() > 0) begin
        id = rt_id_q.pop_front();
        add_result(KIND_DISPATCHED, id, 2'(RT_LVL), rt_dl_q.pop_front());
        found = 1'b1;
      end
      for (int l = RT_LVL - 1; l >= 0 && !found; l--) begin
        if (lvl_id_q[l].size() > 0) begin
          id = lvl_id_q[l].pop_front();
          add_result(KIND_DISPATCHED, id, 2'(l), lvl_dl_q[l].pop_front());
          found = 1'b1;
        end
      end
      if (!found) add_result(KIND_NONE, '0, '0, '0);
    end
    r = expected_results[$];
    r.last = 1'b1;
    expected_results[$] = r;
  endfunction

  // directed table; check_row marks rows whose result is typed in
  typedef struct {
    cmd_t c;
    bit   check_row;
    res_t r;
  } row_t;

  row_t dir_rows[$];

  function automatic cmd_t mk(logic op, logic [1:0] p, logic [63:0] dl, logic [63:0] nw);
    cmd_t c;
    c.opcode = op; c.priority_req = p; c.deadline = dl; c.now_time = nw;
    return c;
  endfunction

  function automatic res_t rs(logic [2:0] k, logic [31:0] id, logic [1:0] p,
                              logic [63:0] dl, logic [6:0] pc);
    res_t r;
    r.kind = k; r.task_id = id; r.task_priority = p; r.task_deadline = dl;
    r.last = 1'b1; r.pending_count = pc;
    return r;
  endfunction

  function automatic void add_row(cmd_t c, bit chk = 1'b0, res_t r = '0);
    row_t w;
    w.c = c; w.check_row = chk; w.r = r;
    dir_rows.push_back(w);
  endfunction

  task automatic send_cmd(cmd_t c);
    push <= 1'b1;
    opcode <= c.opcode; priority_req <= c.priority_req;
    deadline <= c.deadline; now_time <= c.now_time;
    do @(posedge clk); while (full);
    schedule_cmd(c);
    // random gaps, mostly short, sometimes long, often none
    if ($urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic drain_and_idle();
    push <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    expire_en_we <= 1'b1;
    expire_en_wdata <= v;
    @(posedge clk);
    expire_en_we <= 1'b0;
    mode_rt = v;
  endtask

  function automatic logic [63:0] rand_dl(bit near);
    logic [63:0] v;
    if (near) return 64'($urandom_range(0, 40));
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: v = DL_MAX;
      1: v = '0;
      default: ;
    endcase
    return v;
  endfunction

  // result side: pop with random stalls, compare against the model
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d id=%0d", kind, task_id);
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind || task_id !== want.task_id ||
              task_priority !== want.task_priority ||
              task_deadline !== want.task_deadline || last !== want.last ||
              pending_count !== want.pending_count) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp k=%0d id=%0d p=%0d dl=%h l=%0d pc=%0d",
                       want.kind, want.task_id, want.task_priority, want.task_deadline,
                       want.last, want.pending_count);
              $display("         got k=%0d id=%0d p=%0d dl=%h l=%0d pc=%0d",
                       kind, task_id, task_priority, task_deadline, last, pending_count);
            end
          end
        end
      end
      pop <= hold_pop ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver hold-off for a long stretch so the block fills and stalls push
  initial begin
    wait (hold_go);
    repeat (20) @(posedge clk);
    hold_pop = 1'b1;
    repeat (300) @(posedge clk);
    hold_pop = 1'b0;
  end

  initial begin
    cmd_t c;
    int n_rand;
    bit near;
    id_counter = 32'd1;
    mode_rt = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty dispatch, extremes, every level, stable equal deadlines, a full realtime level
    add_row(mk(OP_DISPATCH, 2'd0, '0, DL_MAX), 1, rs(KIND_NONE, '0, '0, '0, '0));
    add_row(mk(OP_SUBMIT, 2'd0, '0, '0), 1, rs(KIND_ACCEPTED, 32'd1, 2'd0, '0, 7'd1));
    add_row(mk(OP_SUBMIT, 2'd1, DL_MAX, DL_MAX), 1,
            rs(KIND_ACCEPTED, 32'd2, 2'd1, DL_MAX, 7'd2));
    add_row(mk(OP_SUBMIT, 2'd2, 64'h5555_5555_5555_5555, '0));
    add_row(mk(OP_SUBMIT, 2'd3, 64'd100, '0));
    add_row(mk(OP_SUBMIT, 2'd3, 64'd50, '0));
    add_row(mk(OP_SUBMIT, 2'd3, 64'd100, '0));
    add_row(mk(OP_SUBMIT, 2'd3, 64'hAAAA_AAAA_AAAA_AAAA, '0));
    for (int i = 0; i < 6; i++) add_row(mk(OP_DISPATCH, 2'd3, '0, DL_MAX));
    for (int i = 0; i < 17; i++) add_row(mk(OP_SUBMIT, 2'd3, 64'(i % 3), '0));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].c);
      if (dir_rows[i].check_row && expected_results[$] !== dir_rows[i].r) begin
        errors++;
        if (errors <= 10) $display("model disagrees with table row %0d", i);
      end
    end
    drain_and_idle();

    // realtime mode on: expire a full realtime queue, equal deadline not expired
    write_mode(1'b1);
    send_cmd(mk(OP_DISPATCH, 2'd0, '0, 64'd2));
    send_cmd(mk(OP_DISPATCH, 2'd0, '0, DL_MAX));
    drain_and_idle();

    // random phases alternating the mode
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      if (ph == 1) hold_go = 1'b1;
      n_rand = 50;
      near = (ph >= 2);
      for (int i = 0; i < n_rand; i++) begin
        c.opcode = ($urandom_range(0, 9) < 6) ? OP_SUBMIT : OP_DISPATCH;
        c.priority_req = 2'($urandom_range(0, 3));
        c.deadline = rand_dl(near);
        c.now_time = rand_dl(near);
        send_cmd(c);
      end
      drain_and_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/pdts_pkg.sv
src/pdts_cmd_fifo.sv
src/pdts_engine.sv
src/priority_deadline_task_scheduler_top.sv
tb/tb_priority_deadline_task_scheduler_top.sv
